// ===== rtl/core/clock_replacement_policy_defines.svh =====
// ----------------------------------------------------------------------------
// Clock replacement policy assertion macros
// Concurrent assertion helpers, empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef CLOCK_REPLACEMENT_POLICY_DEFINES_SVH
`define CLOCK_REPLACEMENT_POLICY_DEFINES_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define CRP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("clock replacement policy assertion failed");
// The condition must never be true outside reset.
`define CRP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("clock replacement policy forbidden condition seen");
`else
`define CRP_ASSERT(lbl, clk, rst_n, prop)
`define CRP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== rtl/core/crp_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock replacement policy package
// Request codes, frame entry layout and the result record.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned FRAME_W = 6;
  localparam int unsigned COUNT_W = 7;

  localparam logic [FUNC_W-1:0] FUNC_VICTIM = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PIN    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UNPIN  = 2'd2;

  // Each frame entry holds a candidate bit and a reference bit.
  localparam int unsigned ENTRY_W  = 2;
  localparam int unsigned CAND_BIT = 1;
  localparam int unsigned REF_BIT  = 0;

  typedef struct packed {
    logic               victim_found;
    logic [FRAME_W-1:0] victim_frame;
    logic [COUNT_W-1:0] candidate_count;
  } result_t;

endpackage

// ===== rtl/core/crp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crp_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/crp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Clock replacement controller
// Sequencer over the frame table: clearing pass, pin/unpin updates and the
// victim sweep of the hand, with the candidate count.
// ----------------------------------------------------------------------------
`include "clock_replacement_policy_defines.svh"

module crp_ctrl #(
  parameter int unsigned NUM_FRAMES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [crp_pkg::FUNC_W-1:0]  func_i,
  input  logic [crp_pkg::FRAME_W-1:0] frame_id_i,
  input  logic                        out_free_i,
  output logic                        res_load_o,
  output crp_pkg::result_t            res_o
);

  localparam int unsigned AW = $clog2(NUM_FRAMES);
  localparam int unsigned CW = $clog2(NUM_FRAMES + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RESP  = 3'd2;
  localparam logic [2:0] S_RMW   = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;

  localparam logic [AW-1:0] LAST_FRAME = AW'(NUM_FRAMES - 1);

  logic [2:0]                 state_q, state_d;
  logic [AW-1:0]              hand_q, hand_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [AW-1:0]              clr_q, clr_d;
  logic [crp_pkg::FUNC_W-1:0] func_q, func_d;
  logic [AW-1:0]              fidx_q, fidx_d;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [crp_pkg::ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [crp_pkg::ENTRY_W-1:0] ram_rdata;

  logic          hit_cand;
  logic          hit_ref;
  logic          frame_ok;
  logic [AW-1:0] hand_nxt;

  crp_ram #(
    .WIDTH (crp_pkg::ENTRY_W),
    .DEPTH (NUM_FRAMES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign hit_cand   = ram_rdata[crp_pkg::CAND_BIT];
  assign hit_ref    = ram_rdata[crp_pkg::REF_BIT];
  assign frame_ok   = 32'(frame_id_i) < NUM_FRAMES;
  assign hand_nxt   = (hand_q == LAST_FRAME) ? '0 : hand_q + 1'b1;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    hand_d     = hand_q;
    cnt_d      = cnt_q;
    clr_d      = clr_q;
    func_d     = func_q;
    fidx_d     = fidx_q;
    ram_we     = 1'b0;
    ram_waddr  = hand_q;
    ram_wdata  = '0;
    ram_raddr  = hand_q;
    res_load_o = 1'b0;
    res_o      = '0;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == LAST_FRAME) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          fidx_d = AW'(frame_id_i);
          if (func_i == crp_pkg::FUNC_VICTIM) begin
            // The read of the hand entry is issued now and lands next cycle.
            state_d = (cnt_q == '0) ? S_RESP : S_SWEEP;
          end else if ((func_i inside {crp_pkg::FUNC_PIN, crp_pkg::FUNC_UNPIN})
                       && frame_ok) begin
            ram_raddr = AW'(frame_id_i);
            state_d   = S_RMW;
          end else begin
            state_d = S_RESP;
          end
        end
      end

      S_RESP: begin
        res_o.candidate_count = crp_pkg::COUNT_W'(cnt_q);
        if (out_free_i) begin
          res_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end

      S_RMW: begin
        // Re-reading the same entry keeps the read data steady while waiting.
        ram_raddr = fidx_q;
        if (out_free_i) begin
          ram_we    = 1'b1;
          ram_waddr = fidx_q;
          if (func_q == crp_pkg::FUNC_PIN) begin
            ram_wdata = '0;
            if (hit_cand) begin
              cnt_d = cnt_q - 1'b1;
            end
          end else begin
            ram_wdata[crp_pkg::CAND_BIT] = 1'b1;
            ram_wdata[crp_pkg::REF_BIT]  = 1'b1;
            if (!hit_cand) begin
              cnt_d = cnt_q + 1'b1;
            end
          end
          res_o.candidate_count = crp_pkg::COUNT_W'(cnt_d);
          res_load_o            = 1'b1;
          state_d               = S_IDLE;
        end
      end

      S_SWEEP: begin
        // One frame per cycle unless a found victim waits for the output: the
        // next entry is read while a referenced one is written back.
        if (!hit_cand) begin
          hand_d    = hand_nxt;
          ram_raddr = hand_nxt;
        end else if (hit_ref) begin
          ram_we                       = 1'b1;
          ram_waddr                    = hand_q;
          ram_wdata[crp_pkg::CAND_BIT] = 1'b1;
          hand_d                       = hand_nxt;
          ram_raddr                    = hand_nxt;
        end else if (out_free_i) begin
          ram_we                = 1'b1;
          ram_waddr             = hand_q;
          cnt_d                 = cnt_q - 1'b1;
          res_o.victim_found    = 1'b1;
          res_o.victim_frame    = crp_pkg::FRAME_W'(hand_q);
          res_o.candidate_count = crp_pkg::COUNT_W'(cnt_d);
          res_load_o            = 1'b1;
          state_d               = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      hand_q  <= '0;
      cnt_q   <= '0;
      clr_q   <= '0;
      func_q  <= crp_pkg::FUNC_VICTIM;
      fidx_q  <= '0;
    end else begin
      state_q <= state_d;
      hand_q  <= hand_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      func_q  <= func_d;
      fidx_q  <= fidx_d;
    end
  end

  `CRP_ASSERT(a_count_in_range, clk_i, rst_ni, cnt_q <= CW'(NUM_FRAMES))
  `CRP_ASSERT(a_evict_needs_candidate, clk_i, rst_ni,
              (res_load_o && res_o.victim_found) |-> (cnt_q != '0))
  `CRP_ASSERT_NEVER(a_load_into_busy_output, clk_i, rst_ni, res_load_o && !out_free_i)
  `CRP_ASSERT(a_count_changes_on_update, clk_i, rst_ni,
              (cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_RMW
                                           || $past(state_q) == S_SWEEP))
  `CRP_ASSERT(a_no_request_during_clear, clk_i, rst_ni,
              (state_q == S_CLEAR) |=> (state_q == S_CLEAR || state_q == S_IDLE))

endmodule

// ===== rtl/core/crp_out.sv =====
// ----------------------------------------------------------------------------
// Clock replacement result register
// Holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module crp_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          res_load_i,
  input  crp_pkg::result_t              res_i,
  output logic                          out_free_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          victim_found_o,
  output logic [crp_pkg::FRAME_W-1:0]   victim_frame_o,
  output logic [crp_pkg::COUNT_W-1:0]   candidate_count_o
);

  logic             valid_q;
  crp_pkg::result_t res_q;

  // The register can take a new result when empty or emptied this cycle.
  assign out_free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o       = valid_q;
  assign victim_found_o    = res_q.victim_found;
  assign victim_frame_o    = res_q.victim_frame;
  assign candidate_count_o = res_q.candidate_count;

endmodule

// ===== rtl/core/clock_replacement_policy.sv =====
// ----------------------------------------------------------------------------
// Clock replacement policy
// Second-chance frame replacement over a table of candidate/reference bits.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the input channel (in_valid_i/in_stall_o) with a kind
//   in func_i (victim, pin, unpin) and a frame in frame_id_i. Every request
//   produces exactly one transaction on the output channel
//   (out_valid_o/out_stall_i) carrying victim_found_o, victim_frame_o and
//   the candidate count left after the request.
//   Pin, unpin, unused kinds, out-of-range frames and a victim request with
//   no candidates pass through one response state (S_RMW or S_RESP), which
//   loads the result into the output register before returning to idle.
//   In a victim sweep the hand passes over at most 2 * NUM_FRAMES frames
//   before eviction. The frame table is one RAM with registered read data;
//   the sweep visits one frame per cycle while no found victim waits for
//   the output register, reading the next entry while writing back a
//   referenced current one. After reset the table is cleared one entry per
//   cycle, all NUM_FRAMES entries, during which in_stall_o is high.
//   A result waits in an output register while out_stall_i is high; the
//   block still accepts one further request and holds its result until the
//   output register frees up.
// ----------------------------------------------------------------------------
module clock_replacement_policy #(
  parameter int unsigned NUM_FRAMES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [crp_pkg::FUNC_W-1:0]  func_i,
  input  logic [crp_pkg::FRAME_W-1:0] frame_id_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        victim_found_o,
  output logic [crp_pkg::FRAME_W-1:0] victim_frame_o,
  output logic [crp_pkg::COUNT_W-1:0] candidate_count_o
);

  logic             out_free;
  logic             res_load;
  crp_pkg::result_t res;

  crp_ctrl #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .frame_id_i (frame_id_i),
    .out_free_i (out_free),
    .res_load_o (res_load),
    .res_o      (res)
  );

  crp_out u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .res_load_i        (res_load),
    .res_i             (res),
    .out_free_o        (out_free),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .victim_found_o    (victim_found_o),
    .victim_frame_o    (victim_frame_o),
    .candidate_count_o (candidate_count_o)
  );

endmodule
